// ===== hdl/strr_pkg.sv =====
// Package for the scaled text row rasterizer: constants, types and font lookup.
package strr_pkg;

    localparam logic [11:0] SCREEN_WIDTH  = 12'd320;
    localparam logic [11:0] SCREEN_HEIGHT = 12'd240;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [5:0] GLYPH_DIGIT0 = 6'd26;
    localparam logic [5:0] GLYPH_SPACE  = 6'd36;
    localparam logic [5:0] GLYPH_DOT    = 6'd37;
    localparam logic [5:0] GLYPH_COLON  = 6'd38;
    localparam logic [5:0] GLYPH_PLUS   = 6'd39;
    localparam logic [5:0] GLYPH_MINUS  = 6'd40;
    localparam logic [5:0] GLYPH_LT     = 6'd41;
    localparam logic [5:0] GLYPH_GT     = 6'd42;
    localparam logic [5:0] GLYPH_SLASH  = 6'd43;

    typedef struct packed {
        logic signed [11:0] a;
        logic [4:0]         b;
        logic [11:0]        limit;
    } t_alu_op;

    typedef struct packed {
        logic signed [11:0] sat_sum;
        logic               fits;
    } t_alu_res;

    function automatic logic [5:0] glyph_of(input logic [7:0] code);
        logic [5:0] g;
        g = GLYPH_SPACE;
        case (code) inside
            [8'h41:8'h5A]: g = 6'(code - 8'h41);
            [8'h61:8'h7A]: g = 6'(code - 8'h61);
            [8'h30:8'h39]: g = GLYPH_DIGIT0 + 6'(code - 8'h30);
            8'h2E:         g = GLYPH_DOT;
            8'h3A:         g = GLYPH_COLON;
            8'h2B:         g = GLYPH_PLUS;
            8'h2D:         g = GLYPH_MINUS;
            8'h3C:         g = GLYPH_LT;
            8'h3E:         g = GLYPH_GT;
            8'h2F:         g = GLYPH_SLASH;
            default:       g = GLYPH_SPACE;
        endcase
        return g;
    endfunction

    // Seven 5-bit rows, top row in the upper bits.
    function automatic logic [34:0] font_glyph(input logic [5:0] g);
        logic [34:0] f;
        case (g)
            6'd0:  f = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            6'd1:  f = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
            6'd2:  f = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd16, 5'd14};
            6'd3:  f = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
            6'd4:  f = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
            6'd5:  f = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
            6'd6:  f = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14};
            6'd7:  f = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            6'd8:  f = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31};
            6'd9:  f = {5'd7,  5'd2,  5'd2,  5'd2,  5'd3,  5'd2,  5'd12};
            6'd10: f = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
            6'd11: f = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
            6'd12: f = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
            6'd13: f = {5'd17, 5'd25, 5'd29, 5'd27, 5'd17, 5'd17, 5'd17};
            6'd14: f = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            6'd15: f = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
            6'd16: f = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
            6'd17: f = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
            6'd18: f = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
            6'd19: f = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
            6'd20: f = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            6'd21: f = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd8,  5'd8};
            6'd22: f = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd27, 5'd17};
            6'd23: f = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd20, 5'd9};
            6'd24: f = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
            6'd25: f = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
            6'd26: f = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
            6'd27: f = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
            6'd28: f = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
            6'd29: f = {5'd31, 5'd1,  5'd1,  5'd6,  5'd1,  5'd17, 5'd14};
            6'd30: f = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
            6'd31: f = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
            6'd32: f = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
            6'd33: f = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
            6'd34: f = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
            6'd35: f = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
            6'd36: f = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0};
            6'd37: f = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd4};
            6'd38: f = {5'd0,  5'd2,  5'd0,  5'd0,  5'd0,  5'd8,  5'd0};
            6'd39: f = {5'd0,  5'd2,  5'd0,  5'd31, 5'd4,  5'd2,  5'd0};
            6'd40: f = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
            6'd41: f = {5'd1,  5'd2,  5'd4,  5'd2,  5'd0,  5'd16, 5'd4};
            6'd42: f = {5'd16, 5'd4,  5'd2,  5'd2,  5'd4,  5'd8,  5'd16};
            6'd43: f = {5'd1,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd16};
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [4:0] glyph_row(input logic [34:0] f, input logic [2:0] r);
        logic [4:0] bits;
        case (r)
            3'd0:    bits = f[34:30];
            3'd1:    bits = f[29:25];
            3'd2:    bits = f[24:20];
            3'd3:    bits = f[19:15];
            3'd4:    bits = f[14:10];
            3'd5:    bits = f[9:5];
            3'd6:    bits = f[4:0];
            default: bits = '0;
        endcase
        return bits;
    endfunction

    // Replicates each of the 5 columns eff times, left-justified in 15 bits.
    function automatic logic [14:0] expand_row(input logic [4:0] bits, input logic [1:0] eff);
        logic [14:0] m;
        m = '0;
        case (eff)
            2'd2: begin
                for (int c = 0; c < 5; c++) begin
                    m[14 - 2 * c] = bits[4 - c];
                    m[13 - 2 * c] = bits[4 - c];
                end
            end
            2'd3: begin
                for (int c = 0; c < 5; c++) begin
                    m[14 - 3 * c] = bits[4 - c];
                    m[13 - 3 * c] = bits[4 - c];
                    m[12 - 3 * c] = bits[4 - c];
                end
            end
            default: m = {bits, 10'b0};
        endcase
        return m;
    endfunction

    function automatic logic [3:0] width_of(input logic [1:0] eff);
        logic [3:0] w;
        case (eff)
            2'd2:    w = 4'd10;
            2'd3:    w = 4'd15;
            default: w = 4'd5;
        endcase
        return w;
    endfunction

    function automatic logic [4:0] height_of(input logic [1:0] eff);
        logic [4:0] h;
        case (eff)
            2'd2:    h = 5'd14;
            2'd3:    h = 5'd21;
            default: h = 5'd7;
        endcase
        return h;
    endfunction

    function automatic logic [4:0] advance_of(input logic [1:0] scale);
        logic [4:0] a;
        case (scale)
            2'd1:    a = 5'd6;
            2'd2:    a = 5'd12;
            2'd3:    a = 5'd18;
            default: a = 5'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/strr_alu.sv =====
// Shared saturating coordinate adder with screen-fit compare.
module strr_alu (
    input  strr_pkg::t_alu_op  i_op,
    output strr_pkg::t_alu_res o_res
);
    import strr_pkg::*;

    logic [11:0] sum;

    // b is non-negative, so only the upper bound can overflow.
    assign sum = i_op.a + 12'(i_op.b);
    assign o_res.sat_sum = (!i_op.a[11] && sum[11]) ? 12'sh7FF : sum;
    assign o_res.fits    = !i_op.a[11] && (sum <= i_op.limit);

endmodule

// ===== hdl/scaled_text_row_rasterizer.sv =====
// Top level of the scaled text row rasterizer.
// Sequence: an accepted character goes through S_CHKX and S_CHKY, then S_ROWS if it fits on screen.
// A drawn character emits 7*eff rows (eff = scale, 1 at scale 0) while the output is free, output
// stalls holding it, then S_ADV. Off screen it goes to S_ADV; a newline to S_NL. One item at a time.
// All steps share one saturating adder/compare unit.
// Reset (synchronous, active low): cursor and origin 0, glyph_scale 1, idle.
module scaled_text_row_rasterizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_start_text,
    input  logic signed [11:0] i_text_x,
    input  logic signed [11:0] i_text_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_window_x,
    output logic [10:0] o_window_y,
    output logic [4:0]  o_row_index,
    output logic [3:0]  o_row_width,
    output logic [14:0] o_row_mask,
    output logic        o_last_row,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);
    import strr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHKX = 3'd1;
    localparam logic [2:0] S_CHKY = 3'd2;
    localparam logic [2:0] S_ROWS = 3'd3;
    localparam logic [2:0] S_ADV  = 3'd4;
    localparam logic [2:0] S_NL   = 3'd5;

    logic [2:0]         r_state;
    logic [1:0]         r_scale;
    logic signed [11:0] r_origin, r_cur_x, r_cur_y;
    logic [5:0]         r_glyph;
    logic               r_fit_x, r_fit;
    logic [4:0]         r_py;
    logic [2:0]         r_grow;
    logic [1:0]         r_sub;
    logic               r_out_valid;
    logic [10:0]        r_out_x, r_out_y;
    logic [4:0]         r_out_idx;
    logic [3:0]         r_out_w;
    logic [14:0]        r_out_mask;
    logic               r_out_last;

    logic [1:0]  eff;
    logic [4:0]  h;
    logic        in_acc, out_free, emit, row_last;
    t_alu_op     alu_op;
    t_alu_res    alu_res;

    assign eff      = (r_scale == 2'd0) ? 2'd1 : r_scale;
    assign h        = height_of(eff);
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign emit     = (r_state == S_ROWS) && out_free;
    assign row_last = (r_py == h - 5'd1);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        alu_op = '{a: r_cur_x, b: {1'b0, width_of(eff)}, limit: SCREEN_WIDTH};
        case (r_state)
            S_CHKY:  alu_op = '{a: r_cur_y, b: h, limit: SCREEN_HEIGHT};
            S_ADV:   alu_op = '{a: r_cur_x, b: advance_of(r_scale), limit: SCREEN_WIDTH};
            S_NL:    alu_op = '{a: r_cur_y, b: {r_scale, 3'b000}, limit: SCREEN_HEIGHT};
            default: alu_op = '{a: r_cur_x, b: {1'b0, width_of(eff)}, limit: SCREEN_WIDTH};
        endcase
    end

    strr_alu u_alu (
        .i_op  (alu_op),
        .o_res (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scale     <= 2'd1;
            r_origin    <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_scale <= i_cfg_data;
            end
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= emit;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_start_text) begin
                            r_origin <= i_text_x;
                            r_cur_x  <= i_text_x;
                            r_cur_y  <= i_text_y;
                        end
                        r_state <= (i_char_code == CHAR_NEWLINE) ? S_NL : S_CHKX;
                    end
                end
                S_CHKX: begin
                    r_state <= S_CHKY;
                end
                S_CHKY: begin
                    r_state <= (r_fit_x && alu_res.fits) ? S_ROWS : S_ADV;
                end
                S_ROWS: begin
                    if (emit && row_last) begin
                        r_state <= S_ADV;
                    end
                end
                S_ADV: begin
                    r_cur_x <= alu_res.sat_sum;
                    r_state <= S_IDLE;
                end
                S_NL: begin
                    r_cur_y <= alu_res.sat_sum;
                    r_cur_x <= r_origin;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_glyph <= glyph_of(i_char_code);
        end
        if (r_state == S_CHKX) begin
            r_fit_x <= alu_res.fits;
        end
        if (r_state == S_CHKY) begin
            r_fit  <= r_fit_x && alu_res.fits;
            r_py   <= '0;
            r_grow <= '0;
            r_sub  <= '0;
        end
        if (emit) begin
            r_out_x    <= r_cur_x[10:0];
            r_out_y    <= r_cur_y[10:0];
            r_out_idx  <= r_py;
            r_out_w    <= width_of(eff);
            r_out_mask <= expand_row(glyph_row(font_glyph(r_glyph), r_grow), eff);
            r_out_last <= row_last;
            r_py       <= r_py + 5'd1;
            if (r_sub == eff - 2'd1) begin
                r_sub  <= '0;
                r_grow <= r_grow + 3'd1;
            end else begin
                r_sub <= r_sub + 2'd1;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_window_x  = r_out_x;
    assign o_window_y  = r_out_y;
    assign o_row_index = r_out_idx;
    assign o_row_width = r_out_w;
    assign o_row_mask  = r_out_mask;
    assign o_last_row  = r_out_last;

    a_rows_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROWS) |-> r_fit)
        else $error("rows emitted for a character off screen");

    a_mask_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_row_mask & (15'h7FFF >> o_row_width)) == 15'd0))
        else $error("mask bits right of row width");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_row) |->
            ((o_row_width == 4'd5 && o_row_index == 5'd6) ||
             (o_row_width == 4'd10 && o_row_index == 5'd13) ||
             (o_row_width == 4'd15 && o_row_index == 5'd20)))
        else $error("last row flag on wrong row");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("sequencer did not start on accepted transaction");

endmodule
